@@ src/aesg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-GCM engine package
// Shared types, register indexes, the S-box table and the AES round and
// GF(2^128) multiply functions used by the key schedule and the datapath.
// ----------------------------------------------------------------------------
package aesg_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned TDATA_W = 136;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_FIXED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_START = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MODE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd7;

  typedef enum logic [1:0] {
    OP_AAD    = 2'd0,
    OP_TEXT   = 2'd1,
    OP_FINISH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    OUT_TEXT   = 2'd0,
    OUT_TAG    = 2'd1,
    OUT_STATUS = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    IK_AAD  = 2'd0,
    IK_TEXT = 2'd1,
    IK_FIN  = 2'd2,
    IK_HKEY = 2'd3
  } item_kind_e;

  typedef struct packed {
    item_kind_e           kind;
    logic                 open;
    logic [4:0]           nbytes;
    logic [BLOCK_W-1:0]   blk;
    logic [BLOCK_W-1:0]   data;
    logic [BLOCK_W-1:0]   lens;
  } item_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } auth_rsp_t;

  localparam logic [2047:0] SBOX_TABLE = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    logic [10:0] idx;
    idx = 11'd2047 - {b, 3'b000};
    return SBOX_TABLE[idx -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] rcon(input logic [2:0] idx);
    return 8'h01 << idx;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round: SubBytes, ShiftRows, MixColumns (skipped in the last
  // round) and AddRoundKey. Byte 0 sits in the top bits of the block.
  function automatic logic [BLOCK_W-1:0] aes_round(input logic [BLOCK_W-1:0] s,
                                                   input logic [BLOCK_W-1:0] rk,
                                                   input logic last);
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < 16; i++) begin
      t[i] = sbox(s[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        u[4*c+r] = t[4*((c+r) & 3)+r];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[4*c];
        a1 = u[4*c+1];
        a2 = u[4*c+2];
        a3 = u[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        u[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        u[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        u[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        u[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = u[i];
    end
    return o ^ rk;
  endfunction

  function automatic logic [BLOCK_W-1:0] bit_rev(input logic [BLOCK_W-1:0] a);
    logic [BLOCK_W-1:0] r;
    for (int i = 0; i < BLOCK_W; i++) begin
      r[i] = a[BLOCK_W-1-i];
    end
    return r;
  endfunction

  // GHASH multiply. After bit reversal bit i is the coefficient of x^i, so
  // this is a carry-less product reduced by x^128 + x^7 + x^2 + x + 1.
  function automatic logic [BLOCK_W-1:0] gf_mul(input logic [BLOCK_W-1:0] x,
                                                input logic [BLOCK_W-1:0] h);
    logic [BLOCK_W-1:0] a, b, r;
    logic [254:0] p;
    logic [133:0] hx, t;
    logic [127:0] ux;
    a = bit_rev(x);
    b = bit_rev(h);
    p = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      if (a[i]) begin
        p = p ^ ({127'b0, b} << i);
      end
    end
    hx = {7'b0, p[254:128]};
    t = hx ^ (hx << 1) ^ (hx << 2) ^ (hx << 7);
    ux = {122'b0, t[133:128]};
    r = p[127:0] ^ t[127:0] ^ ux ^ (ux << 1) ^ (ux << 2) ^ (ux << 7);
    return bit_rev(r);
  endfunction

  function automatic logic [BLOCK_W-1:0] byte_mask(input logic [4:0] n);
    logic [BLOCK_W-1:0] m;
    for (int i = 0; i < 16; i++) begin
      m[127-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

@@ src/aes256_gcm_ssh_aead.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256-GCM AEAD engine for SSH packets
// Requests pass through the queue, AES_ROUNDS+1 cipher stages, the GHASH
// stage and the output register. Throughput: one request per cycle while
// the output is not stalled, set by the fully pipelined AES rounds and the
// combinational GHASH multiply. After an open-mode finish, requests are held
// until the status returns. Reset and every write to an index below REG_COUNT
// run the key schedule (one word per cycle) and an H pass, holding tready low.
// ----------------------------------------------------------------------------
module aes256_gcm_ssh_aead #(
  parameter int unsigned AES_ROUNDS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aesg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [aesg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_high [63:0], data_low [127:64], valid_bytes [132:128], zero pad
  input  logic [aesg_pkg::TDATA_W-1:0]      s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_high [63:0], out_low [127:64], out_bytes [132:128], auth_ok [133], zero pad
  output logic [aesg_pkg::TDATA_W-1:0]      m_axis_tdata,
  // out_kind [1:0]
  output logic [1:0]                        m_axis_tuser
);

  localparam int unsigned KEY_WORDS = 4 * (AES_ROUNDS + 1);

  logic                   back_ready, q_full, q_push, q_valid, q_pop, ks_done;
  aesg_pkg::item_t        push_item, head_item;
  aesg_pkg::auth_rsp_t    rsp;
  logic [32*KEY_WORDS-1:0] rk;

  aesg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tuser_i    (s_axis_tuser),
    .s_tdata_i    (s_axis_tdata),
    .s_tready_o   (s_axis_tready),
    .back_ready_i (back_ready),
    .q_full_i     (q_full),
    .rsp_i        (rsp),
    .push_o       (q_push),
    .item_o       (push_item)
  );

  aesg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  aesg_keysched #(.AES_ROUNDS(AES_ROUNDS)) u_keysched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rk_o        (rk),
    .done_o      (ks_done)
  );

  aesg_back #(.AES_ROUNDS(AES_ROUNDS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .ks_done_i   (ks_done),
    .rk_i        (rk),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .ready_o     (back_ready),
    .rsp_o       (rsp),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("request pushed into a full queue");

  a_no_push_during_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_ready |-> !q_push)
    else $error("request queued before the key schedule and H were ready");

  a_status_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !s_axis_tready)
    else $error("open-mode status returned while requests were not held");

  a_open_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && push_item.kind == aesg_pkg::IK_FIN && push_item.open) |=> !s_axis_tready)
    else $error("request accepted right after an open-mode finish");

endmodule

@@ src/aesg_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-GCM request queue
// Short register queue that decouples the classifying front from the
// cipher and hash back end.
// ----------------------------------------------------------------------------
module aesg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  aesg_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output aesg_pkg::item_t item_o
);

  localparam int unsigned PtrW = $clog2(aesg_pkg::QUEUE_DEPTH);

  aesg_pkg::item_t   mem_q [aesg_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(aesg_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

@@ src/aesg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-GCM request front
// Accepts requests, masks data, tracks the message phase, counters and
// length totals, and queues classified work for the back end.
// ----------------------------------------------------------------------------
module aesg_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aesg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [aesg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_tvalid_i,
  input  logic [1:0]                        s_tuser_i,
  input  logic [aesg_pkg::TDATA_W-1:0]      s_tdata_i,
  output logic                              s_tready_o,
  input  logic                              back_ready_i,
  input  logic                              q_full_i,
  input  aesg_pkg::auth_rsp_t               rsp_i,
  output logic                              push_o,
  output aesg_pkg::item_t                   item_o
);

  localparam logic [1:0] PH_AAD       = 2'd0;
  localparam logic [1:0] PH_AAD_DONE  = 2'd1;
  localparam logic [1:0] PH_TEXT      = 2'd2;
  localparam logic [1:0] PH_TEXT_DONE = 2'd3;

  logic [31:0] nonce_fixed_q, nonce_fixed_d;
  logic [63:0] inv_q, inv_d;
  logic        open_q, open_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] ctr_q, ctr_d;
  logic [63:0] aad_len_q, aad_len_d, txt_len_q, txt_len_d;
  logic        wait_q, wait_d;

  aesg_pkg::opcode_e          op;
  logic [4:0]                 n_raw, n;
  logic [aesg_pkg::BLOCK_W-1:0] din;
  logic                       accept;
  logic [63:0]                nbits;

  assign op     = aesg_pkg::opcode_e'(s_tuser_i);
  assign n_raw  = s_tdata_i[132:128];
  assign n      = (n_raw > 5'd16) ? 5'd16 : n_raw;
  assign din    = {s_tdata_i[63:0], s_tdata_i[127:64]};
  assign nbits  = {56'b0, n, 3'b000};
  // A pending open-mode check holds requests back, since the next nonce
  // depends on whether the tag matched.
  assign s_tready_o = back_ready_i && !q_full_i && !wait_q && !cfg_we_i;
  assign accept = s_tvalid_i && s_tready_o;

  always_comb begin
    nonce_fixed_d = nonce_fixed_q;
    inv_d         = inv_q;
    open_d        = open_q;
    phase_d       = phase_q;
    ctr_d         = ctr_q;
    aad_len_d     = aad_len_q;
    txt_len_d     = txt_len_q;
    wait_d        = wait_q;
    push_o        = 1'b0;
    item_o.kind   = aesg_pkg::IK_AAD;
    item_o.open   = open_q;
    item_o.nbytes = n;
    item_o.blk    = {nonce_fixed_q, inv_q, ctr_q};
    item_o.data   = din & aesg_pkg::byte_mask(n);
    item_o.lens   = {aad_len_q, txt_len_q};

    if (accept) begin
      case (op)
        aesg_pkg::OP_AAD: begin
          if (phase_q == PH_AAD && n != 5'd0) begin
            push_o    = 1'b1;
            aad_len_d = aad_len_q + nbits;
            if (n < 5'd16) begin
              phase_d = PH_AAD_DONE;
            end
          end
        end
        aesg_pkg::OP_TEXT: begin
          if (phase_q != PH_TEXT_DONE && n != 5'd0) begin
            push_o      = 1'b1;
            item_o.kind = aesg_pkg::IK_TEXT;
            ctr_d       = ctr_q + 32'd1;
            txt_len_d   = txt_len_q + nbits;
            phase_d     = (n < 5'd16) ? PH_TEXT_DONE : PH_TEXT;
          end
        end
        aesg_pkg::OP_FINISH: begin
          push_o      = 1'b1;
          item_o.kind = aesg_pkg::IK_FIN;
          item_o.blk  = {nonce_fixed_q, inv_q, 32'd1};
          item_o.data = din;
          aad_len_d   = '0;
          txt_len_d   = '0;
          ctr_d       = 32'd2;
          phase_d     = PH_AAD;
          if (open_q) begin
            wait_d = 1'b1;
          end else begin
            inv_d = inv_q + 64'd1;
          end
        end
        default: ;
      endcase
    end

    if (rsp_i.valid && wait_q) begin
      inv_d  = inv_q + {63'b0, rsp_i.ok};
      wait_d = 1'b0;
    end

    if (cfg_we_i && cfg_index_i < aesg_pkg::REG_COUNT) begin
      aad_len_d = '0;
      txt_len_d = '0;
      ctr_d     = 32'd2;
      phase_d   = PH_AAD;
      wait_d    = 1'b0;
      case (cfg_index_i)
        aesg_pkg::REG_NONCE_FIXED: nonce_fixed_d = cfg_data_i[31:0];
        aesg_pkg::REG_CTR_START:   inv_d = cfg_data_i;
        aesg_pkg::REG_OPEN_MODE:   open_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonce_fixed_q <= '0;
      inv_q         <= '0;
      open_q        <= 1'b0;
      phase_q       <= PH_AAD;
      ctr_q         <= 32'd2;
      aad_len_q     <= '0;
      txt_len_q     <= '0;
      wait_q        <= 1'b0;
    end else begin
      nonce_fixed_q <= nonce_fixed_d;
      inv_q         <= inv_d;
      open_q        <= open_d;
      phase_q       <= phase_d;
      ctr_q         <= ctr_d;
      aad_len_q     <= aad_len_d;
      txt_len_q     <= txt_len_d;
      wait_q        <= wait_d;
    end
  end

endmodule

@@ src/aesg_keysched.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-GCM key schedule
// Holds the key registers and expands them one word per cycle through a
// shift line that ends up holding the whole round key schedule.
// ----------------------------------------------------------------------------
module aesg_keysched #(
  parameter int unsigned AES_ROUNDS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aesg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [aesg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic [32*4*(AES_ROUNDS+1)-1:0]    rk_o,
  output logic                              done_o
);

  localparam int unsigned KEY_WORDS = 4 * (AES_ROUNDS + 1);
  localparam int unsigned CNT_W = $clog2(KEY_WORDS);

  localparam logic [1:0] KS_LOAD = 2'd0;
  localparam logic [1:0] KS_RUN  = 2'd1;
  localparam logic [1:0] KS_DONE = 2'd2;

  logic [63:0]      key_q [4];
  logic [31:0]      w_q [KEY_WORDS];
  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      prev, tmp, nw;
  logic [CNT_W-4:0] grp;
  logic             restart;

  assign restart = cfg_we_i && cfg_index_i < aesg_pkg::REG_COUNT;
  assign prev    = w_q[KEY_WORDS-1];
  assign grp     = cnt_q[CNT_W-1:3] - 1'b1;

  always_comb begin
    case (cnt_q[2:0])
      3'd0: tmp = aesg_pkg::sub_word({prev[23:0], prev[31:24]}) ^
                  {aesg_pkg::rcon(grp[2:0]), 24'b0};
      3'd4: tmp = aesg_pkg::sub_word(prev);
      default: tmp = prev;
    endcase
    nw = w_q[KEY_WORDS-8] ^ tmp;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      KS_LOAD: begin
        state_d = KS_RUN;
        cnt_d   = CNT_W'(8);
      end
      KS_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(KEY_WORDS - 1)) begin
          state_d = KS_DONE;
        end
      end
      default: ;
    endcase
    if (restart) begin
      state_d = KS_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_LOAD;
      cnt_q   <= '0;
      for (int k = 0; k < 4; k++) begin
        key_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i && cfg_index_i <= aesg_pkg::REG_KEY3) begin
        key_q[cfg_index_i[1:0]] <= cfg_data_i;
      end
    end
  end

  // The key words enter at the tail; after the expansion the first key
  // word has shifted down to the head of the line.
  always_ff @(posedge clk_i) begin
    if (state_q == KS_LOAD) begin
      for (int k = 0; k < 4; k++) begin
        w_q[KEY_WORDS-8+2*k]   <= key_q[k][63:32];
        w_q[KEY_WORDS-8+2*k+1] <= key_q[k][31:0];
      end
    end else if (state_q == KS_RUN) begin
      for (int j = 0; j < KEY_WORDS - 1; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[KEY_WORDS-1] <= nw;
    end
  end

  always_comb begin
    for (int j = 0; j < KEY_WORDS; j++) begin
      rk_o[32*j +: 32] = w_q[j];
    end
  end

  assign done_o = (state_q == KS_DONE);

endmodule

@@ src/aesg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-GCM cipher and hash back end
// Pipelined AES keystream, one GHASH multiply per block, tag build and
// compare, and the output register.
// ----------------------------------------------------------------------------
module aesg_back #(
  parameter int unsigned AES_ROUNDS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aesg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic                              ks_done_i,
  input  logic [32*4*(AES_ROUNDS+1)-1:0]    rk_i,
  input  logic                              q_valid_i,
  input  aesg_pkg::item_t                   q_item_i,
  output logic                              q_pop_o,
  output logic                              ready_o,
  output aesg_pkg::auth_rsp_t               rsp_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [aesg_pkg::TDATA_W-1:0]      m_tdata_o,
  output logic [1:0]                        m_tuser_o
);

  localparam int unsigned BW = aesg_pkg::BLOCK_W;

  localparam logic [1:0] H_WAIT  = 2'd0;
  localparam logic [1:0] H_ISSUE = 2'd1;
  localparam logic [1:0] H_BUSY  = 2'd2;
  localparam logic [1:0] H_DONE  = 2'd3;

  logic [1:0]      h_state_q, h_state_d;
  logic [BW-1:0]   h_key_q, acc_q;
  logic            en, restart, inject, in_vld;
  aesg_pkg::item_t in_item;

  logic            vld_q [AES_ROUNDS+1];
  logic [BW-1:0]   st_q  [AES_ROUNDS+1];
  aesg_pkg::item_t it_q  [AES_ROUNDS+1];
  logic [BW-1:0]   rnd   [AES_ROUNDS+1];
  logic [BW-1:0]   rkey  [AES_ROUNDS+1];

  aesg_pkg::item_t e_it;
  logic [BW-1:0]   ks, ct, fold, prod;
  logic            e_vld;

  logic                   g_vld_q;
  aesg_pkg::item_kind_e   g_kind_q;
  logic                   g_open_q;
  logic [4:0]             g_n_q;
  logic [BW-1:0]          g_a_q, g_b_q, g_c_q, tag;
  logic                   tag_ok;

  logic                   o_vld_q;
  aesg_pkg::out_kind_e    o_kind_q;
  logic [BW-1:0]          o_blk_q;
  logic [4:0]             o_n_q;
  logic                   o_auth_q;

  // The whole pipeline advances together whenever the output can move.
  assign en      = !o_vld_q || m_tready_i;
  assign restart = cfg_we_i && cfg_index_i < aesg_pkg::REG_COUNT;
  assign inject  = (h_state_q == H_ISSUE);
  assign ready_o = (h_state_q == H_DONE);
  assign q_pop_o = en && q_valid_i && ready_o;
  assign in_vld  = q_pop_o || (en && inject);

  always_comb begin
    in_item = q_item_i;
    if (inject) begin
      in_item      = '0;
      in_item.kind = aesg_pkg::IK_HKEY;
    end
  end

  genvar r;
  generate
    for (r = 0; r <= AES_ROUNDS; r++) begin : g_rk
      assign rkey[r] = {rk_i[32*(4*r) +: 32], rk_i[32*(4*r+1) +: 32],
                        rk_i[32*(4*r+2) +: 32], rk_i[32*(4*r+3) +: 32]};
      if (r == 0) begin : g_first
        assign rnd[r] = in_item.blk ^ rkey[r];
      end else begin : g_round
        assign rnd[r] = aesg_pkg::aes_round(st_q[r-1], rkey[r], r == AES_ROUNDS);
      end
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= AES_ROUNDS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_vld;
      for (int i = 1; i <= AES_ROUNDS; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= rnd[0];
      it_q[0] <= in_item;
      for (int i = 1; i <= AES_ROUNDS; i++) begin
        st_q[i] <= rnd[i];
        it_q[i] <= it_q[i-1];
      end
    end
  end

  assign e_it  = it_q[AES_ROUNDS];
  assign ks    = st_q[AES_ROUNDS];
  assign e_vld = vld_q[AES_ROUNDS] && en;
  assign ct    = (e_it.data ^ ks) & aesg_pkg::byte_mask(e_it.nbytes);

  always_comb begin
    case (e_it.kind)
      aesg_pkg::IK_AAD:  fold = e_it.data;
      aesg_pkg::IK_TEXT: fold = e_it.open ? e_it.data : ct;
      aesg_pkg::IK_FIN:  fold = e_it.lens;
      default:           fold = '0;
    endcase
    prod = aesg_pkg::gf_mul(acc_q ^ fold, h_key_q);
  end

  always_comb begin
    h_state_d = h_state_q;
    case (h_state_q)
      H_WAIT:  if (ks_done_i) h_state_d = H_ISSUE;
      H_ISSUE: if (en) h_state_d = H_BUSY;
      H_BUSY:  if (e_vld && e_it.kind == aesg_pkg::IK_HKEY) h_state_d = H_DONE;
      default: ;
    endcase
    if (restart) begin
      h_state_d = H_WAIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_state_q <= H_WAIT;
      acc_q     <= '0;
      g_vld_q   <= 1'b0;
      o_vld_q   <= 1'b0;
    end else begin
      h_state_q <= h_state_d;
      if (restart) begin
        acc_q <= '0;
      end else if (e_vld) begin
        case (e_it.kind)
          aesg_pkg::IK_AAD, aesg_pkg::IK_TEXT: acc_q <= prod;
          aesg_pkg::IK_FIN: acc_q <= '0;
          default: ;
        endcase
      end
      if (en) begin
        g_vld_q <= vld_q[AES_ROUNDS] &&
                   (e_it.kind == aesg_pkg::IK_TEXT || e_it.kind == aesg_pkg::IK_FIN);
        o_vld_q <= g_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_vld && e_it.kind == aesg_pkg::IK_HKEY) begin
      h_key_q <= ks;
    end
    if (en) begin
      g_kind_q <= e_it.kind;
      g_open_q <= e_it.open;
      g_n_q    <= e_it.nbytes;
      g_a_q    <= (e_it.kind == aesg_pkg::IK_TEXT) ? ct : prod;
      g_b_q    <= ks;
      g_c_q    <= e_it.data;
    end
  end

  assign tag    = g_a_q ^ g_b_q;
  assign tag_ok = (tag == g_c_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (g_kind_q == aesg_pkg::IK_TEXT) begin
        o_kind_q <= aesg_pkg::OUT_TEXT;
        o_blk_q  <= g_a_q;
        o_n_q    <= g_n_q;
        o_auth_q <= !g_open_q;
      end else if (g_open_q) begin
        o_kind_q <= aesg_pkg::OUT_STATUS;
        o_blk_q  <= '0;
        o_n_q    <= 5'd0;
        o_auth_q <= tag_ok;
      end else begin
        o_kind_q <= aesg_pkg::OUT_TAG;
        o_blk_q  <= tag;
        o_n_q    <= 5'd16;
        o_auth_q <= 1'b1;
      end
    end
  end

  assign rsp_o.valid = en && g_vld_q && g_kind_q == aesg_pkg::IK_FIN && g_open_q;
  assign rsp_o.ok    = tag_ok;

  assign m_tvalid_o = o_vld_q;
  assign m_tdata_o  = {2'b00, o_auth_q, o_n_q, o_blk_q[63:0], o_blk_q[127:64]};
  assign m_tuser_o  = o_kind_q;

endmodule
